// ----- src/sbus_rfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sbus_rfd_pkg
// Shared types, constants and decode functions of the sbus remote frame decoder
// ----------------------------------------------------------------------------
package sbus_rfd_pkg;

  localparam int unsigned FRAME_LEN = 25;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned NUM_CH    = 7;
  localparam int unsigned CH_W      = 11;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] FOOTER_BYTE = 8'h00;

  localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] FLAG_IDX  = CNT_W'(23);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(FRAME_LEN);
  localparam int unsigned      FLAG_BIT  = 3;

  // switch codes
  localparam logic [1:0] SW_ERROR = 2'd0;
  localparam logic [1:0] SW_DOWN  = 2'd1;
  localparam logic [1:0] SW_MID   = 2'd2;
  localparam logic [1:0] SW_UP    = 2'd3;

  localparam logic [CH_W-1:0] CH_DOWN = 11'd511;
  localparam logic [CH_W-1:0] CH_MID  = 11'd1024;
  localparam logic [CH_W-1:0] CH_UP   = 11'd1541;

  // result causes
  localparam logic [1:0] CAUSE_GOOD    = 2'd0;
  localparam logic [1:0] CAUSE_DISC    = 2'd1;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

  // config register indexes
  localparam logic CFG_TIMEOUT  = 1'b0;
  localparam logic CFG_DEADBAND = 1'b1;

  localparam logic [15:0] TIMEOUT_RST = 16'd100;

  // stick scaling: q = (mag*16384 + 330) / 660 = (mag*4096 + 82) / 165
  localparam logic [10:0] MAG_CLAMP   = 11'd660;
  localparam logic [14:0] Q_ONE       = 15'd16384;
  localparam logic [22:0] ROUND_OFS   = 23'd82;
  localparam logic [22:0] RECIP_MUL   = 23'd6507527;
  localparam int unsigned RECIP_SHIFT = 30;

  typedef struct packed {
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic signed [15:0] stick_pitch;
    logic signed [15:0] stick_yaw;
    logic signed [15:0] stick_wheel;
    logic [1:0]         left_switch;
    logic [1:0]         right_switch;
    logic               link_up;
    logic               protect_on;
    logic [1:0]         cause;
  } result_t;

  function automatic logic signed [15:0] scale_stick(input logic [CH_W-1:0] v,
                                                     input logic            negate,
                                                     input logic [14:0]     deadband);
    logic [11:0] d;
    logic        neg;
    logic [10:0] mag;
    logic [22:0] num;
    logic [45:0] prod;
    logic [14:0] q;
    logic [15:0] qe;
    d    = {1'b0, v} - 12'd1024;
    neg  = d[11];
    mag  = neg ? 11'(-d) : d[10:0];
    num  = {mag, 12'd0} + ROUND_OFS;
    prod = 46'(num) * 46'(RECIP_MUL);
    q    = prod[RECIP_SHIFT+14:RECIP_SHIFT];
    if (mag > MAG_CLAMP) begin
      q = Q_ONE;
    end
    if (q < deadband) begin
      q = 15'd0;
    end
    qe = {1'b0, q};
    return (neg ^ negate) ? -qe : qe;
  endfunction

  function automatic logic [1:0] decode_switch(input logic [CH_W-1:0] v);
    logic [1:0] code;
    case (v)
      CH_DOWN: code = SW_DOWN;
      CH_MID:  code = SW_MID;
      CH_UP:   code = SW_UP;
      default: code = SW_ERROR;
    endcase
    return code;
  endfunction

endpackage

// ----- src/sbus_remote_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// sbus_remote_frame_decoder_top
// Decodes sbus frames from a byte and tick stream into stick, switch and link
// results
//
// channel   dir  beat contents
// s_axis    in   tdata rx_byte, tlast frame_end, tuser req_type
// m_axis    out  tdata sticks/switches/flags, tuser cause
// cfg       in   cfg_addr_i register index, cfg_data_i value
//
// one beat per cycle while the result is not stalled; a beat is taken into the
// input register and its result is then registered in the result stage
// the five stick scalers each hold one reciprocal multiplier in the result stage
// reset clears counters and the link timeout to 100, deadband to 0
// a stalled result holds the result stage; the input register still takes one beat
// ----------------------------------------------------------------------------
module sbus_remote_frame_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // stick_x, stick_y, stick_pitch, stick_yaw,
                                      // stick_wheel, left_switch, right_switch,
                                      // link_up, protect_on, zero pad
  output logic [1:0]  m_axis_tuser,   // cause
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_data_i
);
  import sbus_rfd_pkg::*;

  logic        in_valid_q;
  logic        in_req_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;

  logic [15:0] timeout_q;
  logic [14:0] deadband_q;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      ticks_q, ticks_d;
  logic [7:0]       store_q [FRAME_LEN];

  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  logic        advance;
  logic        proc;
  logic [15:0] ticks_inc;
  logic        timeout_hit;
  logic        frame_ok;
  logic        disc;
  logic [79:0] ch_bits;
  logic [CH_W-1:0] ch [NUM_CH];
  result_t     res_good;
  result_t     res_drop;

  assign advance       = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TIMEOUT_RST;
      deadband_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_TIMEOUT:  timeout_q  <= cfg_data_i;
        CFG_DEADBAND: deadband_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // frame bytes
  always_ff @(posedge clk_i) begin
    if (proc && !in_req_q && (cnt_q < FULL_CNT)) begin
      store_q[cnt_q] <= in_byte_q;
    end
  end

  // channel unpacking, bytes 1..10
  always_comb begin
    for (int b = 0; b < 10; b++) begin
      ch_bits[8*b +: 8] = store_q[b+1];
    end
    for (int c = 0; c < NUM_CH; c++) begin
      ch[c] = ch_bits[CH_W*c +: CH_W];
    end
  end

  assign ticks_inc   = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
  assign timeout_hit = ticks_inc > timeout_q;
  assign frame_ok    = in_last_q && (cnt_q == LAST_IDX) &&
                       (store_q[0] == HEADER_BYTE) && (in_byte_q == FOOTER_BYTE);
  assign disc        = store_q[FLAG_IDX][FLAG_BIT];

  always_comb begin
    res_good.stick_x      = scale_stick(ch[1], 1'b0, deadband_q);
    res_good.stick_y      = scale_stick(ch[0], 1'b1, deadband_q);
    res_good.stick_pitch  = scale_stick(ch[2], 1'b0, deadband_q);
    res_good.stick_yaw    = scale_stick(ch[3], 1'b1, deadband_q);
    res_good.stick_wheel  = scale_stick(ch[4], 1'b0, deadband_q);
    res_good.left_switch  = decode_switch(ch[5]);
    res_good.right_switch = decode_switch(ch[6]);
    res_good.link_up      = 1'b1;
    res_good.protect_on   = (res_good.left_switch != SW_DOWN);
    res_good.cause        = CAUSE_GOOD;

    res_drop              = '0;
    res_drop.protect_on   = 1'b1;
    res_drop.cause        = in_req_q ? CAUSE_TIMEOUT : CAUSE_DISC;
  end

  // result stage
  always_comb begin
    cnt_d       = cnt_q;
    ticks_d     = ticks_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    res_d       = res_q;
    if (proc) begin
      if (in_req_q) begin
        ticks_d = ticks_inc;
        if (timeout_hit) begin
          out_valid_d = 1'b1;
          res_d       = res_drop;
        end
      end else begin
        if (cnt_q <= FULL_CNT) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (in_last_q) begin
          cnt_d = '0;
          if (frame_ok) begin
            out_valid_d = 1'b1;
            if (disc) begin
              res_d = res_drop;
            end else begin
              res_d   = res_good;
              ticks_d = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.cause;
  assign m_axis_tdata  = {2'b00, res_q.protect_on, res_q.link_up, res_q.right_switch,
                          res_q.left_switch, res_q.stick_wheel, res_q.stick_yaw,
                          res_q.stick_pitch, res_q.stick_y, res_q.stick_x};

  // byte count never runs past one beyond a full frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT + CNT_W'(1))
    else $error("byte count overflow");

  // a dropped-link result carries cleared sticks and protect on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != CAUSE_GOOD) |->
      (m_axis_tdata[85:0] == {1'b1, 85'd0}))
    else $error("reset result not cleared");

  // a good frame restarts the tick counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && !in_req_q && frame_ok && !disc |=> ticks_q == 16'd0)
    else $error("tick counter not cleared by good frame");

  // a burst end always restarts the byte count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && !in_req_q && in_last_q |=> cnt_q == '0)
    else $error("byte count not cleared at burst end");

  // good results show link up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == CAUSE_GOOD) |-> m_axis_tdata[84])
    else $error("good result without link up");

endmodule
